// ===== rtl/double_ended_queue_with_sum_top_assert.svh =====
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared assertion wrappers for the deque with running sum.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_SUM_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SUM_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DQS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dqsum_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Word types, command and status codes shared by the deque modules.
// ----------------------------------------------------------------------------
package dqsum_pkg;

  // Default number of entries in the ring store.
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  // Command codes as they arrive on the input word.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SUM        = 3'd5;

  // Status codes of a result word.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Command queue between front and back; the depth is a power of two.
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Decoded operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_LIST,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_SUM
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [STATUS_W-1:0]       status;
    logic                      last;
  } out_word_t;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_word_t;

endpackage

// ===== rtl/double_ended_queue_with_sum_top.sv =====
// ----------------------------------------------------------------------------
// Deque with running sum
// Bounded double-ended queue of signed 32-bit values with a wrapping total.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i, in_stall_o and in_word_i carry one command word
// (push front/back, pop front/back, list, sum). Output channel: out_valid_o,
// out_stall_i and out_word_o carry result words with value, status and last.
// A front stage decodes and queues commands in a two-entry command queue; the
// back end executes them against the ring store and a registered output word.
// A command passes the command queue and then the registered output word; a
// pop or a list that finds entries also passes the registered read port of
// the ring store. Pushes and sums run at one word per cycle while out_stall_i
// is low; a pop waits for its registered read, and a list then streams one
// word per cycle while out_stall_i is low. Unused command codes are accepted
// and give no result.
// Reset empties the queue and clears the running total; store contents are
// not cleared. While out_stall_i is high the result word holds, the back end
// waits, and in_stall_o rises once the command queue has filled.
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_sum_top_assert.svh"

module double_ended_queue_with_sum_top #(
  parameter int unsigned QUEUE_DEPTH = dqsum_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dqsum_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dqsum_pkg::out_word_t out_word_o
);
  import dqsum_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             cmd_valid;
  cmd_word_t        cmd_word;
  logic             cmd_pop;
  logic [CNT_W-1:0] count;

  dqsum_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_word_o  (cmd_word),
    .cmd_pop_i   (cmd_pop)
  );

  dqsum_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_word_i  (cmd_word),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .count_o     (count)
  );

  // A refused or empty result carries a zero value and ends its command.
  `DQS_ASSERT_IMP(a_fail_word, clk_i, rst_ni, out_valid_o && (out_word_o.status != ST_OK), (out_word_o.result_value == '0) && out_word_o.last, "failure word not zero or not last")

  // A full status is only shown while the store is full.
  `DQS_ASSERT_IMP(a_full_count, clk_i, rst_ni, out_valid_o && (out_word_o.status == ST_FULL), count == CNT_W'(QUEUE_DEPTH), "full status with store not full")

  // An empty status is only shown while the store is empty.
  `DQS_ASSERT_IMP(a_empty_count, clk_i, rst_ni, out_valid_o && (out_word_o.status == ST_EMPTY), count == '0, "empty status with entries present")

  // The entry count cannot move while a result word is held back.
  `DQS_ASSERT_NEXT(a_hold_count, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(count), "entry count changed under a stalled result")

endmodule

// ===== rtl/dqsum_ram.sv =====
// ----------------------------------------------------------------------------
// Deque RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqsum_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port and registered read port; read data holds when not enabled.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/dqsum_front.sv =====
// ----------------------------------------------------------------------------
// Deque front end
// Accepts input words, decodes the command and queues it for the back end.
// ----------------------------------------------------------------------------
module dqsum_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dqsum_pkg::in_word_t  in_word_i,
  output logic                 cmd_valid_o,
  output dqsum_pkg::cmd_word_t cmd_word_o,
  input  logic                 cmd_pop_i
);
  import dqsum_pkg::*;

  cmd_word_t             cmdq_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;

  logic      accept;
  logic      known;
  op_e       op;
  logic      push;
  logic      pop;

  // Decode the command; unused codes are accepted and dropped.
  always_comb begin
    known = 1'b1;
    op    = OP_SUM;
    unique case (in_word_i.cmd)
      CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
      CMD_PUSH_BACK:  op = OP_PUSH_BACK;
      CMD_LIST:       op = OP_LIST;
      CMD_POP_FRONT:  op = OP_POP_FRONT;
      CMD_POP_BACK:   op = OP_POP_BACK;
      CMD_SUM:        op = OP_SUM;
      default:        known = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && known;
  assign pop        = cmd_pop_i && (cnt_q != '0);

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_word_o  = cmdq_q[rd_ptr_q];

  // Pointer and fill count update; pointers wrap as the depth is a power of two.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + CMDQ_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + CMDQ_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CMDQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CMDQ_CNT_W'(1);
    end
  end

  // Queue control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue payload.
  always_ff @(posedge clk_i) begin
    if (push) begin
      cmdq_q[wr_ptr_q] <= '{op: op, value: in_word_i.push_value};
    end
  end

endmodule

// ===== rtl/dqsum_back.sv =====
// ----------------------------------------------------------------------------
// Deque back end
// Executes queued commands against the ring store and drives result words.
// ----------------------------------------------------------------------------
module dqsum_back #(
  parameter int unsigned QUEUE_DEPTH = dqsum_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  dqsum_pkg::cmd_word_t cmd_word_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dqsum_pkg::out_word_t out_word_o,
  output logic [CNT_W-1:0]     count_o
);
  import dqsum_pkg::*;

  localparam int unsigned SUM_W = IDX_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [VALUE_W-1:0] total_q, total_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic               pop_front_q, pop_front_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, out_word_d;

  logic               out_free;
  logic               is_empty;
  logic               is_full;
  logic [IDX_W-1:0]   head_inc;
  logic [IDX_W-1:0]   head_dec;
  logic [CNT_W-1:0]   pos_nxt;
  logic               list_last;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_data;

  // Ring slot of the entry at a given distance from the head.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, head} + SUM_W'(pos);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  dqsum_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (cmd_word_i.value),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_inc  = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
  assign head_dec  = (head_q == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_q - IDX_W'(1);
  assign pos_nxt   = pos_q + CNT_W'(1);
  assign list_last = (pos_nxt == count_q);

  // Command sequencer. The count, head and total change only together with
  // loading a result word, so they hold while a result waits.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    total_d     = total_q;
    pos_d       = pos_q;
    pop_front_d = pop_front_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    cmd_pop_o   = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = slot_of(head_q, count_q);
    rd_en       = 1'b0;
    rd_addr     = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_word_i.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                out_word_d = '{result_value: '0, status: ST_FULL, last: 1'b1};
              end else begin
                wr_en = 1'b1;
                if (cmd_word_i.op == OP_PUSH_FRONT) begin
                  wr_addr = head_dec;
                  head_d  = head_dec;
                end
                count_d    = count_q + CNT_W'(1);
                total_d    = total_q + cmd_word_i.value;
                out_word_d = '{result_value: '0, status: ST_OK, last: 1'b1};
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                out_word_d  = '{result_value: '0, status: ST_EMPTY, last: 1'b1};
              end else begin
                rd_en       = 1'b1;
                pop_front_d = (cmd_word_i.op == OP_POP_FRONT);
                if (cmd_word_i.op == OP_POP_BACK) begin
                  rd_addr = slot_of(head_q, count_q - CNT_W'(1));
                end
                state_d = S_POP;
              end
            end
            OP_LIST: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                out_word_d  = '{result_value: '0, status: ST_EMPTY, last: 1'b1};
              end else begin
                rd_en   = 1'b1;
                pos_d   = '0;
                state_d = S_LIST;
              end
            end
            OP_SUM: begin
              out_valid_d = 1'b1;
              if (is_empty) begin
                out_word_d = '{result_value: '0, status: ST_EMPTY, last: 1'b1};
              end else begin
                out_word_d = '{result_value: total_q, status: ST_OK, last: 1'b1};
              end
            end
            default: begin
              // Nothing to do; the word is only dropped.
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '{result_value: rd_data, status: ST_OK, last: 1'b1};
          count_d     = count_q - CNT_W'(1);
          total_d     = total_q - rd_data;
          if (pop_front_q) begin
            head_d = head_inc;
          end
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        // One entry per cycle while the output is free; the next read is issued as the current one leaves.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '{result_value: rd_data, status: ST_OK, last: list_last};
          if (list_last) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = slot_of(head_q, pos_nxt);
            pos_d   = pos_nxt;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      pop_front_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      total_q     <= total_d;
      pos_q       <= pos_d;
      pop_front_q <= pop_front_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign count_o     = count_q;

endmodule
